/* rtl/sha256_pkg.sv */
`default_nettype none
package sha256_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] hash_t;

  typedef struct packed {
    logic       wr_en;
    logic [5:0] wr_idx;
    logic [7:0] wr_data;
    logic       shift;
  } sched_ctrl_t;

  localparam int unsigned ROUNDS = 64;
  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned LEN_POS = 56;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam hash_t H_INIT = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  function automatic word_t round_k(input logic [5:0] t);
    word_t k;
    unique case (t)
      6'd0:  k = 32'h428A2F98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hB5C0FBCF;  6'd3:  k = 32'hE9B5DBA5;
      6'd4:  k = 32'h3956C25B;  6'd5:  k = 32'h59F111F1;
      6'd6:  k = 32'h923F82A4;  6'd7:  k = 32'hAB1C5ED5;
      6'd8:  k = 32'hD807AA98;  6'd9:  k = 32'h12835B01;
      6'd10: k = 32'h243185BE;  6'd11: k = 32'h550C7DC3;
      6'd12: k = 32'h72BE5D74;  6'd13: k = 32'h80DEB1FE;
      6'd14: k = 32'h9BDC06A7;  6'd15: k = 32'hC19BF174;
      6'd16: k = 32'hE49B69C1;  6'd17: k = 32'hEFBE4786;
      6'd18: k = 32'h0FC19DC6;  6'd19: k = 32'h240CA1CC;
      6'd20: k = 32'h2DE92C6F;  6'd21: k = 32'h4A7484AA;
      6'd22: k = 32'h5CB0A9DC;  6'd23: k = 32'h76F988DA;
      6'd24: k = 32'h983E5152;  6'd25: k = 32'hA831C66D;
      6'd26: k = 32'hB00327C8;  6'd27: k = 32'hBF597FC7;
      6'd28: k = 32'hC6E00BF3;  6'd29: k = 32'hD5A79147;
      6'd30: k = 32'h06CA6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27B70A85;  6'd33: k = 32'h2E1B2138;
      6'd34: k = 32'h4D2C6DFC;  6'd35: k = 32'h53380D13;
      6'd36: k = 32'h650A7354;  6'd37: k = 32'h766A0ABB;
      6'd38: k = 32'h81C2C92E;  6'd39: k = 32'h92722C85;
      6'd40: k = 32'hA2BFE8A1;  6'd41: k = 32'hA81A664B;
      6'd42: k = 32'hC24B8B70;  6'd43: k = 32'hC76C51A3;
      6'd44: k = 32'hD192E819;  6'd45: k = 32'hD6990624;
      6'd46: k = 32'hF40E3585;  6'd47: k = 32'h106AA070;
      6'd48: k = 32'h19A4C116;  6'd49: k = 32'h1E376C08;
      6'd50: k = 32'h2748774C;  6'd51: k = 32'h34B0BCB5;
      6'd52: k = 32'h391C0CB3;  6'd53: k = 32'h4ED8AA4A;
      6'd54: k = 32'h5B9CCA4F;  6'd55: k = 32'h682E6FF3;
      6'd56: k = 32'h748F82EE;  6'd57: k = 32'h78A5636F;
      6'd58: k = 32'h84C87814;  6'd59: k = 32'h8CC70208;
      6'd60: k = 32'h90BEFFFA;  6'd61: k = 32'hA4506CEB;
      6'd62: k = 32'hBEF9A3F7;  6'd63: k = 32'hC67178F2;
      default: k = 32'h0;
    endcase
    round_k = k;
  endfunction

endpackage
`default_nettype wire

/* rtl/sha256_msg_sched.sv */
`default_nettype none
module sha256_msg_sched (
  input  wire                      clk,
  input  wire sha256_pkg::sched_ctrl_t ctrl,
  output sha256_pkg::word_t        w_head
);

  // The sixteen-word window doubles as the block buffer while bytes are loaded.
  sha256_pkg::word_t win [16];
  sha256_pkg::word_t w_new;
  logic [4:0] lane_base;

  assign lane_base = {~ctrl.wr_idx[1:0], 3'b000};
  assign w_new = sha256_pkg::small_sigma1(win[14]) + win[9]
               + sha256_pkg::small_sigma0(win[1]) + win[0];
  assign w_head = win[0];

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i+1];
      end
      win[15] <= w_new;
    end else if (ctrl.wr_en) begin
      win[ctrl.wr_idx[5:2]][lane_base +: 8] <= ctrl.wr_data;
    end
  end

endmodule
`default_nettype wire

/* rtl/sha256_round.sv */
`default_nettype none
module sha256_round (
  input  wire sha256_pkg::hash_t v,
  input  wire sha256_pkg::word_t w,
  input  wire sha256_pkg::word_t k,
  output sha256_pkg::hash_t      v_next
);

  sha256_pkg::word_t t1;
  sha256_pkg::word_t t2;
  sha256_pkg::word_t ch;
  sha256_pkg::word_t maj;

  assign ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t1  = v[7] + sha256_pkg::big_sigma1(v[4]) + ch + k + w;
  assign t2  = sha256_pkg::big_sigma0(v[0]) + maj;

  always_comb begin
    v_next[7] = v[6];
    v_next[6] = v[5];
    v_next[5] = v[4];
    v_next[4] = v[3] + t1;
    v_next[3] = v[2];
    v_next[2] = v[1];
    v_next[1] = v[0];
    v_next[0] = t1 + t2;
  end

endmodule
`default_nettype wire

/* rtl/sha256_byte_stream_hasher.sv */
// SHA-256 hasher fed one byte per item. A byte item keeps the block idle, except that
// the byte completing a 64-byte block starts a compression (load, 64 rounds through the
// single shared round unit, chaining add), during which in_stall is high. An item with
// end_of_message set runs the padding sequencer, which writes one byte of padding per
// cycle into the block buffer, then one or two compressions, after which the eight
// digest words appear on the output in order, word 0 first, and the block returns to
// its initial value. Output stalls lengthen the finalising. The block takes no new item
// until the last digest word has been taken.
`default_nettype none
module sha256_byte_stream_hasher (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  data_byte,
  input  wire         byte_present,
  input  wire         end_of_message,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  typedef enum logic [2:0] {
    S_IDLE, S_PAD_MARK, S_PAD_ZERO, S_PAD_LEN, S_LOAD, S_COMPRESS, S_ADD, S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    C_IDLE, C_MARK, C_ZERO, C_EMIT
  } cont_t;

  state_t             state;
  cont_t              cont;
  sha256_pkg::hash_t  chain;
  sha256_pkg::hash_t  v;
  sha256_pkg::hash_t  v_next;
  sha256_pkg::word_t  w_head;
  sha256_pkg::sched_ctrl_t sctrl;
  logic [5:0]  round_cnt;
  logic [5:0]  fill;
  logic [63:0] message_bits;
  logic [6:0]  pos;
  logic [6:0]  pad_limit;
  logic        two_blk;
  logic [2:0]  len_idx;
  logic [2:0]  word_idx;
  logic [5:0]  len_base;
  logic        in_accept;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = (state == S_EMIT);
  assign digest_word = chain[word_idx];
  assign word_index  = word_idx;
  assign last_word   = (word_idx == 3'd7);
  assign pad_limit = two_blk ? 7'(sha256_pkg::BLOCK_BYTES) : 7'(sha256_pkg::LEN_POS);
  assign len_base  = {3'(3'd7 - len_idx), 3'b000};

  always_comb begin
    sctrl = '0;
    unique case (state)
      S_IDLE: begin
        sctrl.wr_en   = in_accept && byte_present;
        sctrl.wr_idx  = fill;
        sctrl.wr_data = data_byte;
      end
      S_PAD_MARK: begin
        sctrl.wr_en   = 1'b1;
        sctrl.wr_idx  = fill;
        sctrl.wr_data = sha256_pkg::PAD_BYTE;
      end
      S_PAD_ZERO: begin
        sctrl.wr_en   = (pos < pad_limit);
        sctrl.wr_idx  = pos[5:0];
      end
      S_PAD_LEN: begin
        sctrl.wr_en   = 1'b1;
        sctrl.wr_idx  = {3'b111, len_idx};
        sctrl.wr_data = message_bits[len_base +: 8];
      end
      S_COMPRESS: begin
        sctrl.shift = 1'b1;
      end
      default: begin
        sctrl = '0;
      end
    endcase
  end

  sha256_msg_sched u_sched (
    .clk    (clk),
    .ctrl   (sctrl),
    .w_head (w_head)
  );

  sha256_round u_round (
    .v      (v),
    .w      (w_head),
    .k      (sha256_pkg::round_k(round_cnt)),
    .v_next (v_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cont         <= C_IDLE;
      chain        <= sha256_pkg::H_INIT;
      fill         <= '0;
      message_bits <= '0;
      two_blk      <= 1'b0;
      word_idx     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            if (byte_present) begin
              fill         <= fill + 6'd1;
              message_bits <= message_bits + 64'd8;
              if (fill == 6'd63) begin
                cont  <= end_of_message ? C_MARK : C_IDLE;
                state <= S_LOAD;
              end else if (end_of_message) begin
                state <= S_PAD_MARK;
              end
            end else if (end_of_message) begin
              state <= S_PAD_MARK;
            end
          end
        end
        S_PAD_MARK: begin
          pos     <= {1'b0, fill} + 7'd1;
          two_blk <= (fill[5:3] == 3'b111);
          state   <= S_PAD_ZERO;
        end
        S_PAD_ZERO: begin
          if (pos < pad_limit) begin
            pos <= pos + 7'd1;
          end else if (two_blk) begin
            two_blk <= 1'b0;
            pos     <= '0;
            cont    <= C_ZERO;
            state   <= S_LOAD;
          end else begin
            len_idx <= '0;
            state   <= S_PAD_LEN;
          end
        end
        S_PAD_LEN: begin
          if (len_idx == 3'd7) begin
            cont  <= C_EMIT;
            state <= S_LOAD;
          end else begin
            len_idx <= len_idx + 3'd1;
          end
        end
        S_LOAD: begin
          v         <= chain;
          round_cnt <= '0;
          state     <= S_COMPRESS;
        end
        S_COMPRESS: begin
          v         <= v_next;
          round_cnt <= round_cnt + 6'd1;
          if (round_cnt == 6'(sha256_pkg::ROUNDS - 1)) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + v[i];
          end
          word_idx <= '0;
          unique case (cont)
            C_IDLE: state <= S_IDLE;
            C_MARK: state <= S_PAD_MARK;
            C_ZERO: state <= S_PAD_ZERO;
            C_EMIT: state <= S_EMIT;
            default: state <= S_IDLE;
          endcase
        end
        S_EMIT: begin
          if (!out_stall) begin
            if (word_idx == 3'd7) begin
              chain        <= sha256_pkg::H_INIT;
              fill         <= '0;
              message_bits <= '0;
              state        <= S_IDLE;
            end else begin
              word_idx <= word_idx + 3'd1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/sha256_checker.sv */
`default_nettype none
module sha256_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_stall,
  input wire [7:0]  data_byte,
  input wire        byte_present,
  input wire        end_of_message,
  input wire        out_valid,
  input wire        out_stall,
  input wire [31:0] digest_word,
  input wire [2:0]  word_index,
  input wire        last_word
);

  // A stalled input item stays offered and unchanged until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(data_byte) && $stable(byte_present)
      && $stable(end_of_message))
    else $error("input item changed while stalled");

  // A stalled digest word holds its value and position.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(digest_word) && $stable(word_index))
    else $error("digest item changed while stalled");

  // Digest words leave in order without gaps.
  a_out_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_word |=>
      out_valid && (word_index == 3'($past(word_index) + 3'd1)))
    else $error("digest words out of order");

  // The last flag marks exactly the eighth word.
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_word == (word_index == 3'd7)))
    else $error("last_word does not match word_index");

  // No new item is taken while the digest is being delivered.
  a_busy_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted during digest output");

endmodule

bind sha256_byte_stream_hasher sha256_checker u_chk (.*);
`default_nettype wire

/* tb/sha256_byte_stream_hasher_tb.sv */
`timescale 1ns / 1ps
`default_nettype none
module sha256_byte_stream_hasher_tb;

  localparam int STALL_PERCENT = 21;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 150;
  localparam int RANDOM_ITEMS = 250;

  localparam logic [0:63][31:0] ROUND_CONST = {
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  localparam logic [0:7][31:0] HASH_START = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam int LENGTH_OFFSET = 56;
  localparam int BLOCK_SIZE = 64;

  localparam int BOUNDARY_LENGTHS [0:9] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_entry_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        byte_present = 1'b0;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  logic [31:0]   hash_state [0:7];
  logic [7:0]    msg_buffer [0:BLOCK_SIZE-1];
  int            msg_fill;
  logic [63:0]   msg_bit_count;
  digest_entry_t pending_digest [$];

  bit idle_enable = 1'b1;
  int rx_hold_request = 0;
  int error_count = 0;
  int items_sent = 0;
  int messages_sent = 0;
  int words_checked = 0;
  int quiet_cycles = 0;

  sha256_byte_stream_hasher dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .byte_present(byte_present),
    .end_of_message(end_of_message),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .digest_word(digest_word),
    .word_index(word_index),
    .last_word(last_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_hash();
    int i;
    for (i = 0; i < 8; i++) hash_state[i] = HASH_START[i];
    msg_fill = 0;
    msg_bit_count = 64'd0;
  endfunction

  function automatic void sha_compress();
    logic [31:0] w [0:63];
    logic [31:0] v [0:7];
    logic [31:0] s0, s1, t1, t2;
    int i;
    for (i = 0; i < 16; i++) begin
      w[i] = {msg_buffer[4*i], msg_buffer[4*i+1], msg_buffer[4*i+2], msg_buffer[4*i+3]};
    end
    for (i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (i = 0; i < 8; i++) v[i] = hash_state[i];
    for (i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
  endfunction

  function automatic void predict_digest(input logic [7:0] b, input logic present,
                                         input logic eom);
    int pos;
    int i;
    digest_entry_t entry;
    if (present) begin
      msg_buffer[msg_fill] = b;
      msg_fill++;
      msg_bit_count = msg_bit_count + 64'd8;
      if (msg_fill == BLOCK_SIZE) begin
        sha_compress();
        msg_fill = 0;
      end
    end
    if (!eom) return;
    pos = msg_fill;
    msg_buffer[pos] = PAD_MARK;
    pos++;
    if (pos > LENGTH_OFFSET) begin
      while (pos < BLOCK_SIZE) begin
        msg_buffer[pos] = 8'h00;
        pos++;
      end
      sha_compress();
      pos = 0;
    end
    while (pos < LENGTH_OFFSET) begin
      msg_buffer[pos] = 8'h00;
      pos++;
    end
    for (i = 0; i < 8; i++) msg_buffer[LENGTH_OFFSET + i] = msg_bit_count[63 - 8*i -: 8];
    sha_compress();
    for (i = 0; i < 8; i++) begin
      entry.word = hash_state[i];
      entry.idx = i[2:0];
      entry.last = (i == 7);
      pending_digest.push_back(entry);
    end
    restart_hash();
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("%0t mismatch: %s", $realtime, msg);
  endtask

  task automatic send_item(input logic [7:0] b, input logic present, input logic eom);
    in_valid <= 1'b1;
    data_byte <= b;
    byte_present <= present;
    end_of_message <= eom;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_digest(b, present, eom);
    items_sent++;
    if (eom) messages_sent++;
    if (idle_enable && $urandom_range(99) < STALL_PERCENT) begin
      in_valid <= 1'b0;
      data_byte <= 8'($urandom);
      byte_present <= 1'($urandom);
      end_of_message <= 1'($urandom);
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic send_message(input int len, input bit eom_alone, input int noise_percent);
    int i;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(99) < noise_percent) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, (i == len - 1) && !eom_alone);
    end
    if (eom_alone || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_digest.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (pending_digest.size() == 0) begin
          report_mismatch($sformatf("digest word %h index %0d with nothing expected",
                                    digest_word, word_index));
        end else begin
          digest_entry_t want;
          want = pending_digest.pop_front();
          words_checked++;
          if (digest_word !== want.word)
            report_mismatch($sformatf("digest_word %h, expected %h (index %0d)",
                                      digest_word, want.word, want.idx));
          if (word_index !== want.idx)
            report_mismatch($sformatf("word_index %0d, expected %0d", word_index, want.idx));
          if (last_word !== want.last)
            report_mismatch($sformatf("last_word %b, expected %b at index %0d",
                                      last_word, want.last, want.idx));
        end
      end
      if (rx_hold_request > 0) begin
        rx_hold_request--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_enable && ($urandom_range(99) < STALL_PERCENT);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired after %0d cycles without progress.", WATCHDOG_LIMIT);
        $display("[sha256_byte_stream_hasher] ERROR");
        $finish;
      end
    end
  end

  task automatic test_empty_message();
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'h5A, 1'b0, 1'b1);
    wait_drain();
  endtask

  task automatic test_single_byte_messages();
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'h80, 1'b1, 1'b1);
    wait_drain();
  endtask

  task automatic test_abc_with_separate_end();
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    wait_drain();
  endtask

  task automatic test_output_hold_off();
    rx_hold_request = 400;
    send_message(6, 1'b0, 0);
    send_message(4, 1'b1, 0);
    wait_drain();
  endtask

  task automatic test_back_to_back();
    idle_enable = 1'b0;
    send_message(64, 1'b0, 0);
    send_message(56, 1'b0, 0);
    send_message(3, 1'b1, 0);
    wait_drain();
    idle_enable = 1'b1;
  endtask

  task automatic test_random_messages();
    int len;
    int start;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      case ($urandom_range(9))
        0: len = $urandom_range(0, 3);
        1, 2: len = BOUNDARY_LENGTHS[$urandom_range(0, 9)];
        default: len = $urandom_range(1, 70);
      endcase
      send_message(len, $urandom_range(3) == 0, 10);
    end
    wait_drain();
  endtask

  initial begin
    restart_hash();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_message();
    test_single_byte_messages();
    test_abc_with_separate_end();
    test_output_hold_off();
    test_back_to_back();
    test_random_messages();
    if (pending_digest.size() != 0)
      report_mismatch($sformatf("%0d digest words never arrived", pending_digest.size()));
    $display("Hashed %0d messages from %0d input items; %0d digest words compared.",
             messages_sent, items_sent, words_checked);
    $display("Covered empty and block-boundary lengths, padding spill and output hold-off.");
    if (error_count == 0) begin
      $display("[sha256_byte_stream_hasher] OK");
    end else begin
      $display("[sha256_byte_stream_hasher] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
